[rtl/dsp_pkg.sv]
// Package: shared constants, types and helper functions for the date string parser.
`timescale 1ns / 1ps

package dsp_pkg;

    localparam int MAX_TEXT_LEN = 99;
    localparam int MAX_YEAR     = 999999;

    localparam int FIELD_W = 20;
    localparam int LEN_W   = $clog2(MAX_TEXT_LEN + 2);
    localparam int MOD_W   = 5;

    localparam logic [FIELD_W-1:0] FIELD_CAP = FIELD_W'(MAX_YEAR + 1);
    localparam logic [FIELD_W-1:0] YEAR_MAX  = FIELD_W'(MAX_YEAR);
    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_TEXT_LEN);

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_BIG   = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Scan state; also the snapshot handed on at the end of a string.
    typedef struct packed {
        logic                           started;
        logic                           pending;
        logic [LEN_W-1:0]               len;
        logic [1:0]                     hyphens;
        logic [1:0]                     dots;
        logic                           bad;
        logic [1:0]                     fidx;
        logic [2:0][FIELD_W-1:0]        fval;
        logic [2:0][MOD_W-1:0]          fmod25;
    } dsp_state_t;

    typedef struct packed {
        logic       valid;
        dsp_state_t data;
    } dsp_snap_t;

    // (r * 10 + d) mod 25 for r < 25, d < 10, by reciprocal and one correction.
    function automatic logic [MOD_W-1:0] mod25_step(input logic [MOD_W-1:0] r,
                                                    input logic [3:0] d);
        logic [7:0]  x;
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  rem;
        x    = 8'({3'b000, r} * 8'd10) + {4'b0000, d};
        prod = 16'({8'h00, x} * 16'd163);
        q    = prod[15:12];
        rem  = x - 8'({4'b0000, q} * 8'd25);
        if (rem >= 8'd25)
        begin
            rem = rem - 8'd25;
        end
        return rem[MOD_W-1:0];
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[rtl/dsp_in_if.sv]
// Interface: input byte channel of the date string parser.
`timescale 1ns / 1ps

interface dsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

[rtl/dsp_out_if.sv]
// Interface: result channel of the date string parser.
`timescale 1ns / 1ps

interface dsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [19:0] year_out;

    modport source (output valid, output status, output day_out, output month_out,
                    output year_out, input ready);
    modport sink   (input valid, input status, input day_out, input month_out,
                    input year_out, output ready);
endinterface

[rtl/date_string_parser_top.sv]
// After the edge that accepts the last byte, a string moves through the snapshot and then the result register.
// Throughput: one byte per cycle while item.ready is high; strings may follow one another directly.
// The scan state register holds one byte's update; the snapshot and result registers
// each hold one finished string, so input stalls only when both are full.
// Reset: rst_n asynchronous, active low; clears scan state and both valid flags.
// Top level: date string parser and validator.
`timescale 1ns / 1ps

module date_string_parser_top (
    input  logic      clk,
    input  logic      rst_n,
    dsp_in_if.sink    item,
    dsp_out_if.source result
);
    import dsp_pkg::*;

    dsp_snap_t snap;
    logic      snap_ready;

    dsp_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    dsp_judge u_judge (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_ready (snap_ready),
        .result     (result)
    );

endmodule

[rtl/dsp_scan.sv]
// Byte scanner: trims whitespace, counts separators, accumulates decimal fields.
`timescale 1ns / 1ps

module dsp_scan (
    input  logic            clk,
    input  logic            rst_n,
    dsp_in_if.sink          item,
    output dsp_pkg::dsp_snap_t snap,
    input  logic            snap_ready
);
    import dsp_pkg::*;

    dsp_state_t cur_reg;
    dsp_state_t nxt;
    dsp_state_t snap_reg;
    logic       snap_vld_reg;

    logic               is_blank;
    logic               is_sep;
    logic               is_digit;
    logic [3:0]         digit;
    logic [FIELD_W-1:0] v;
    logic [23:0]        prod;
    logic [FIELD_W-1:0] acc_next;
    logic [MOD_W-1:0]   mod_next;
    logic               accept;

    assign is_blank = (item.char_code == CH_SPACE) ||
                      ((item.char_code >= CH_TAB) && (item.char_code <= CH_CR));
    assign is_sep   = (item.char_code == CH_HYPHEN) || (item.char_code == CH_DOT);
    assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    assign digit    = 4'(item.char_code - CH_ZERO);

    assign v    = cur_reg.fval[cur_reg.fidx];
    assign prod = 24'({4'h0, v} * 24'd10) + {20'h00000, digit};

    always_comb
    begin
        if (v >= FIELD_CAP)
        begin
            acc_next = FIELD_CAP;
        end
        else if (prod > {4'h0, FIELD_CAP})
        begin
            acc_next = FIELD_CAP;
        end
        else
        begin
            acc_next = prod[FIELD_W-1:0];
        end
    end

    assign mod_next = mod25_step(cur_reg.fmod25[cur_reg.fidx], digit);

    always_comb
    begin
        nxt = cur_reg;
        if (item.has_char)
        begin
            if (is_blank)
            begin
                if (cur_reg.started)
                begin
                    nxt.pending = 1'b1;
                end
            end
            else
            begin
                // whitespace inside the content is a bad character
                if (cur_reg.pending)
                begin
                    nxt.bad = 1'b1;
                end
                nxt.started = 1'b1;
                if (cur_reg.len <= LEN_MAX)
                begin
                    nxt.len = cur_reg.len + LEN_W'(1);
                end
                if (is_sep)
                begin
                    if (item.char_code == CH_HYPHEN)
                    begin
                        if (cur_reg.hyphens != 2'd3)
                        begin
                            nxt.hyphens = cur_reg.hyphens + 2'd1;
                        end
                    end
                    else
                    begin
                        if (cur_reg.dots != 2'd3)
                        begin
                            nxt.dots = cur_reg.dots + 2'd1;
                        end
                    end
                    if (cur_reg.fidx < 2'd2)
                    begin
                        nxt.fidx = cur_reg.fidx + 2'd1;
                    end
                end
                else if (is_digit)
                begin
                    nxt.fval[cur_reg.fidx]   = acc_next;
                    nxt.fmod25[cur_reg.fidx] = mod_next;
                end
                else
                begin
                    nxt.bad = 1'b1;
                end
            end
        end
    end

    assign item.ready = !snap_vld_reg || snap_ready;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            snap_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_reg <= item.last ? dsp_state_t'('0) : nxt;
            end
            if (accept && item.last)
            begin
                snap_vld_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                snap_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.last)
        begin
            snap_reg <= nxt;
        end
    end

    assign snap.valid = snap_vld_reg;
    assign snap.data  = snap_reg;

endmodule

[rtl/dsp_judge.sv]
// Validator: classifies the finished string and holds the result register.
`timescale 1ns / 1ps

module dsp_judge (
    input  logic               clk,
    input  logic               rst_n,
    input  dsp_pkg::dsp_snap_t snap,
    output logic               snap_ready,
    dsp_out_if.source          result
);
    import dsp_pkg::*;

    dsp_state_t         s;
    logic [1:0]         st_next;
    logic [FIELD_W-1:0] d;
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] y;
    logic [MOD_W-1:0]   y_mod25;
    logic               leap;
    logic [4:0]         lim;
    logic               ymd;
    logic               dmy;

    logic               out_vld_reg;
    logic [1:0]         status_reg;
    logic [4:0]         day_reg;
    logic [3:0]         month_reg;
    logic [FIELD_W-1:0] year_reg;

    assign s   = snap.data;
    assign ymd = (s.hyphens == 2'd2) && (s.dots == 2'd0);
    assign dmy = (s.hyphens == 2'd0) && (s.dots == 2'd2);

    always_comb
    begin
        if (ymd)
        begin
            y       = s.fval[0];
            m       = s.fval[1];
            d       = s.fval[2];
            y_mod25 = s.fmod25[0];
        end
        else
        begin
            d       = s.fval[0];
            m       = s.fval[1];
            y       = s.fval[2];
            y_mod25 = s.fmod25[2];
        end
    end

    // divisible by 4, and not by 100 unless also by 400
    assign leap = (y[1:0] == 2'b00) && ((y_mod25 != '0) || (y[3:0] == 4'b0000));

    always_comb
    begin
        lim = month_days(m[3:0]);
        if ((m == FIELD_W'(2)) && leap)
        begin
            lim = 5'd29;
        end
    end

    always_comb
    begin
        if (s.len > LEN_MAX)
        begin
            st_next = ST_BAD;
        end
        else if ((s.len == LEN_W'(1)) && (s.hyphens == 2'd1) && !s.bad)
        begin
            st_next = ST_UNDEF;
        end
        else if (s.bad || !(ymd || dmy))
        begin
            st_next = ST_BAD;
        end
        else if (y > YEAR_MAX)
        begin
            st_next = ST_BIG;
        end
        else if ((m < FIELD_W'(1)) || (m > FIELD_W'(12)))
        begin
            st_next = ST_BAD;
        end
        else if ((d < FIELD_W'(1)) || (d > {15'h0000, lim}))
        begin
            st_next = ST_BAD;
        end
        else
        begin
            st_next = ST_VALID;
        end
    end

    assign snap_ready = !out_vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            out_vld_reg <= snap.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.valid && snap_ready)
        begin
            status_reg <= st_next;
            if (st_next == ST_VALID)
            begin
                day_reg   <= d[4:0];
                month_reg <= m[3:0];
                year_reg  <= y;
            end
            else
            begin
                day_reg   <= '0;
                month_reg <= '0;
                year_reg  <= '0;
            end
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.status    = status_reg;
    assign result.day_out   = day_reg;
    assign result.month_out = month_reg;
    assign result.year_out  = year_reg;

endmodule

[rtl/dsp_checker.sv]
// Checker: port-level assertions on the parser result channel, bound to the top level.
`timescale 1ns / 1ps

module dsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  status,
    input logic [4:0]  day_out,
    input logic [3:0]  month_out,
    input logic [19:0] year_out
);
    import dsp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(day_out)
            && $stable(month_out) && $stable(year_out))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_VALID) |->
            (day_out == 5'd0) && (month_out == 4'd0) && (year_out == 20'd0))
        else $error("date fields not cleared on a non-valid status");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_VALID) |->
            (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1))
        else $error("valid date out of range");

    a_year: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_VALID) |-> (year_out <= YEAR_MAX))
        else $error("valid date above the year bound");

endmodule

bind date_string_parser_top dsp_checker u_dsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .status    (result.status),
    .day_out   (result.day_out),
    .month_out (result.month_out),
    .year_out  (result.year_out)
);
